[design/wcpb_pkg.sv]
// ----------------------------------------------------------------------------
// wcpb_pkg: shared types and constants of the waveform column peak bars block
// Holds the configuration register indexes, the field widths and the
// configuration bundle that the datapath modules share.
// ----------------------------------------------------------------------------
package wcpb_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_COLUMN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT       = 2'd2;

    localparam int SPC_W      = 24;
    localparam int COUNT_W    = 13;
    localparam int HEIGHT_W   = 13;
    localparam int COLUMN_W   = 12;
    localparam int HALF_W     = 12;
    localparam int TOP_W      = 12;
    localparam int BOTTOM_W   = 13;
    localparam int SCALED_W   = 11;

    localparam logic [SPC_W-1:0]    SPC_RESET    = 24'd1;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 13'd1800;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd280;

    localparam logic [COUNT_W-1:0]  MAX_COLUMNS = 13'd4096;
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT  = 13'd2;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT  = 13'd4096;

    typedef struct packed {
        logic [SPC_W-1:0]    samples_per_column;
        logic [COUNT_W-1:0]  column_count;
        logic [HEIGHT_W-1:0] image_height;
    } cfg_t;

endpackage

[design/wcpb_accum.sv]
// ----------------------------------------------------------------------------
// wcpb_accum: per-column peak accumulator
// Tracks the sample count, column index and running absolute peak, and
// registers one column event whenever a group of samples completes.
// ----------------------------------------------------------------------------
module wcpb_accum #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wcpb_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    input  logic                          ev_pop,
    output logic                          ev_valid,
    output logic [wcpb_pkg::COLUMN_W-1:0] ev_column,
    output logic [SAMPLE_BITS-2:0]        ev_peak
);
    import wcpb_pkg::*;

    localparam int MAG_W = SAMPLE_BITS - 1;

    logic [SPC_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0] col_idx_reg, col_idx_next;
    logic [MAG_W-1:0]   peak_reg, peak_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [COLUMN_W-1:0] ev_column_reg;
    logic [MAG_W-1:0]   ev_peak_reg;

    logic [SAMPLE_BITS-1:0] negated;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       peak_max;
    logic [SPC_W-1:0]       count_inc;
    logic [COUNT_W-1:0]     cols_eff;
    logic                   active;
    logic                   done;

    always_comb begin
        negated = (~sample) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
        if (!sample[SAMPLE_BITS-1]) begin
            mag = sample[MAG_W-1:0];
        end else if (sample == {1'b1, {MAG_W{1'b0}}}) begin
            mag = {MAG_W{1'b1}};
        end else begin
            mag = negated[MAG_W-1:0];
        end
        peak_max = (mag > peak_reg) ? mag : peak_reg;

        if (cfg.column_count == '0) begin
            cols_eff = {{(COUNT_W-1){1'b0}}, 1'b1};
        end else if (cfg.column_count > MAX_COLUMNS) begin
            cols_eff = MAX_COLUMNS;
        end else begin
            cols_eff = cfg.column_count;
        end

        active    = col_idx_reg < cols_eff;
        count_inc = count_reg + {{(SPC_W-1){1'b0}}, 1'b1};
        done      = active && (count_inc >= cfg.samples_per_column);

        count_next   = count_reg;
        col_idx_next = col_idx_reg;
        peak_next    = peak_reg;
        if (accept) begin
            if (done) begin
                count_next   = '0;
                col_idx_next = col_idx_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                peak_next    = '0;
            end else if (active) begin
                count_next = count_inc;
                peak_next  = peak_max;
            end
            if (last_sample) begin
                count_next   = '0;
                col_idx_next = '0;
                peak_next    = '0;
            end
        end

        if (accept && done) begin
            ev_valid_next = 1'b1;
        end else if (ev_pop) begin
            ev_valid_next = 1'b0;
        end else begin
            ev_valid_next = ev_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            col_idx_reg  <= '0;
            peak_reg     <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            col_idx_reg  <= col_idx_next;
            peak_reg     <= peak_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && done) begin
            ev_column_reg <= col_idx_reg[COLUMN_W-1:0];
            ev_peak_reg   <= peak_max;
        end
    end

    assign ev_valid  = ev_valid_reg;
    assign ev_column = ev_column_reg;
    assign ev_peak   = ev_peak_reg;

endmodule

[design/wcpb_scale.sv]
// ----------------------------------------------------------------------------
// wcpb_scale: peak scaling and bar bounds with the result register
// Scales a column peak to half the image height and registers the bar's
// row bounds for the result channel.
// ----------------------------------------------------------------------------
module wcpb_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wcpb_pkg::cfg_t                cfg,
    input  logic                          ev_valid,
    input  logic [wcpb_pkg::COLUMN_W-1:0] ev_column,
    input  logic [SAMPLE_BITS-2:0]        ev_peak,
    output logic                          ev_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcpb_pkg::COLUMN_W-1:0] m_column,
    output logic [wcpb_pkg::TOP_W-1:0]    m_bar_top,
    output logic [wcpb_pkg::BOTTOM_W-1:0] m_bar_bottom,
    output logic [wcpb_pkg::SCALED_W-1:0] m_scaled_peak
);
    import wcpb_pkg::*;

    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int PROD_W = MAG_W + HALF_W;

    logic                 m_valid_reg, m_valid_next;
    logic [COLUMN_W-1:0]  column_reg;
    logic [TOP_W-1:0]     top_reg;
    logic [BOTTOM_W-1:0]  bottom_reg;
    logic [SCALED_W-1:0]  scaled_reg;

    logic [HEIGHT_W-1:0]  height_eff;
    logic [HALF_W-1:0]    half;
    logic [PROD_W-1:0]    product;
    logic [SCALED_W-1:0]  p;
    logic [TOP_W-1:0]     top;
    logic [BOTTOM_W-1:0]  bottom;
    logic                 advance;

    always_comb begin
        if (cfg.image_height < MIN_HEIGHT) begin
            height_eff = MIN_HEIGHT;
        end else if (cfg.image_height > MAX_HEIGHT) begin
            height_eff = MAX_HEIGHT;
        end else begin
            height_eff = cfg.image_height;
        end
        half    = height_eff[HEIGHT_W-1:1];
        product = PROD_W'(ev_peak) * PROD_W'(half);
        p       = product[MAG_W +: SCALED_W];
        top     = half - TOP_W'(p);
        if (p == '0) begin
            bottom = BOTTOM_W'(half) + {{(BOTTOM_W-1){1'b0}}, 1'b1};
        end else begin
            bottom = BOTTOM_W'(half) + BOTTOM_W'(p);
        end

        advance      = !m_valid_reg || m_ready;
        m_valid_next = advance ? ev_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ev_valid) begin
            column_reg <= ev_column;
            top_reg    <= top;
            bottom_reg <= bottom;
            scaled_reg <= p;
        end
    end

    assign ev_ready      = advance;
    assign m_valid       = m_valid_reg;
    assign m_column      = column_reg;
    assign m_bar_top     = top_reg;
    assign m_bar_bottom  = bottom_reg;
    assign m_scaled_peak = scaled_reg;

endmodule

[design/waveform_column_peak_bars.sv]
// ----------------------------------------------------------------------------
// waveform_column_peak_bars: peak-decimated waveform overview, one bar per column
// Reduces a stream of signed audio samples to one vertical bar per image
// column, sized by the peak absolute sample value of that column.
// ----------------------------------------------------------------------------
// Samples enter on the s_ channel, one item per cycle when s_ready is high.
// Each group of samples_per_column samples yields one item on the m_ channel
// carrying the column index, the bar's first row, the row after its last row
// and the scaled peak. Samples beyond column_count columns give no item, and
// an item flagged s_last_sample restarts the waveform at column 0 after it
// has been counted; an unfinished column is dropped.
// The sample that completes a column shows its result on m_valid after passing
// through the column event register and then the result register, which the
// multiplier feeds combinationally. Throughput is one sample per cycle while
// s_ready is high, set by the peak and count update.
// When the receiver holds m_ready low, the result register and the event
// register both fill and s_ready then drops until the result is taken.
// Reset clears all counters and pipeline valids and loads the register
// defaults: 1 sample per column, 1800 columns, an image height of 280 rows.
// The user makes configuration writes while the block idles; nothing enforces it.
// ----------------------------------------------------------------------------
module waveform_column_peak_bars #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [wcpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wcpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample,
    input  logic                             s_last_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [wcpb_pkg::COLUMN_W-1:0]    m_column,
    output logic [wcpb_pkg::TOP_W-1:0]       m_bar_top,
    output logic [wcpb_pkg::BOTTOM_W-1:0]    m_bar_bottom,
    output logic [wcpb_pkg::SCALED_W-1:0]    m_scaled_peak
);
    import wcpb_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic                   accept;
    logic                   ev_valid;
    logic                   ev_ready;
    logic                   ev_pop;
    logic [COLUMN_W-1:0]    ev_column;
    logic [SAMPLE_BITS-2:0] ev_peak;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLES_PER_COLUMN: begin
                    cfg_next.samples_per_column = cfg_wdata[SPC_W-1:0];
                end
                REG_COLUMN_COUNT: begin
                    cfg_next.column_count = cfg_wdata[COUNT_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_wdata[HEIGHT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.samples_per_column <= SPC_RESET;
            cfg_reg.column_count       <= COUNT_RESET;
            cfg_reg.image_height       <= HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign ev_pop  = ev_valid && ev_ready;
    assign s_ready = !ev_valid || ev_ready;
    assign accept  = s_valid && s_ready;

    wcpb_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .sample      (s_sample),
        .last_sample (s_last_sample),
        .ev_pop      (ev_pop),
        .ev_valid    (ev_valid),
        .ev_column   (ev_column),
        .ev_peak     (ev_peak)
    );

    wcpb_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .ev_valid      (ev_valid),
        .ev_column     (ev_column),
        .ev_peak       (ev_peak),
        .ev_ready      (ev_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column      (m_column),
        .m_bar_top     (m_bar_top),
        .m_bar_bottom  (m_bar_bottom),
        .m_scaled_peak (m_scaled_peak)
    );

endmodule

[design/wcpb_checker.sv]
// ----------------------------------------------------------------------------
// wcpb_checker: port-level checks for waveform_column_peak_bars
// Watches the top level's handshake and result ports and flags results
// whose bar bounds disagree with the scaled peak.
// ----------------------------------------------------------------------------
module wcpb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [wcpb_pkg::COLUMN_W-1:0]    m_column,
    input logic [wcpb_pkg::TOP_W-1:0]       m_bar_top,
    input logic [wcpb_pkg::BOTTOM_W-1:0]    m_bar_bottom,
    input logic [wcpb_pkg::SCALED_W-1:0]    m_scaled_peak
);
    import wcpb_pkg::*;

    // A stalled result item keeps its contents until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column) && $stable(m_bar_top)
            && $stable(m_bar_bottom) && $stable(m_scaled_peak))
        else $error("result item changed while stalled");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The bar spans twice the scaled peak, or one row for a zero peak.
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (14'(m_bar_top) + ((m_scaled_peak == '0) ? 14'd1 :
            (14'(m_scaled_peak) << 1)) == 14'(m_bar_bottom)))
        else $error("bar bounds disagree with scaled peak");

    // Input is only held off while a result waits at the output.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty result register");

endmodule

bind waveform_column_peak_bars wcpb_checker u_wcpb_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the waveform column peak bars block
// Streams signed samples through the block under a series of register
// settings, predicts every column bar in a scoreboard and compares each
// result item field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import wcpb_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int MAG_MAX  = 32767;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [TOP_W-1:0]    bar_top;
        logic [BOTTOM_W-1:0] bar_bottom;
        logic [SCALED_W-1:0] scaled_peak;
    } bar_t;

    class bar_scoreboard;
        cfg_t                cfg;
        logic [SPC_W-1:0]    count_in_col;
        logic [COUNT_W-1:0]  col_idx;
        logic [PEAK_W-1:0]   col_peak;
        bar_t                expected_bars[$];
        int                  mismatches;
        int                  samples_taken;
        int                  bars_checked;

        function new();
            cfg.samples_per_column = SPC_RESET;
            cfg.column_count       = COUNT_RESET;
            cfg.image_height       = HEIGHT_RESET;
            count_in_col  = '0;
            col_idx       = '0;
            col_peak      = '0;
            mismatches    = 0;
            samples_taken = 0;
            bars_checked  = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SAMPLES_PER_COLUMN: cfg.samples_per_column = val[SPC_W-1:0];
                REG_COLUMN_COUNT:       cfg.column_count       = val[COUNT_W-1:0];
                REG_IMAGE_HEIGHT:       cfg.image_height       = val[HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic last);
            int unsigned per_col;
            int unsigned cols;
            int unsigned height;
            int unsigned half;
            int unsigned p;
            int          value;
            int          mag;
            bar_t        bar;
            samples_taken++;
            per_col = (cfg.samples_per_column == 0) ? 1 : cfg.samples_per_column;
            cols = cfg.column_count;
            if (cols == 0) cols = 1;
            if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
            height = cfg.image_height;
            if (height < MIN_HEIGHT) height = MIN_HEIGHT;
            if (height > MAX_HEIGHT) height = MAX_HEIGHT;
            if (col_idx < cols) begin
                value = smp;
                mag = (value < 0) ? -value : value;
                if (mag > MAG_MAX) mag = MAG_MAX;
                if (mag > col_peak) col_peak = PEAK_W'(mag);
                count_in_col = count_in_col + 1'b1;
                if (count_in_col >= per_col) begin
                    half = height >> 1;
                    p = (col_peak * half) >> (SAMPLE_W - 1);
                    bar.column      = col_idx[COLUMN_W-1:0];
                    bar.bar_top     = TOP_W'(half - p);
                    bar.bar_bottom  = (p == 0) ? BOTTOM_W'(half + 1) : BOTTOM_W'(half + p);
                    bar.scaled_peak = SCALED_W'(p);
                    expected_bars.push_back(bar);
                    col_idx      = col_idx + 1'b1;
                    count_in_col = '0;
                    col_peak     = '0;
                end
            end
            if (last) begin
                count_in_col = '0;
                col_idx      = '0;
                col_peak     = '0;
            end
        endfunction

        function void check_result(bar_t got);
            bar_t want;
            bars_checked++;
            if (expected_bars.size() == 0) begin
                $error("Unexpected bar for column %0d with no result pending.", got.column);
                mismatches++;
            end else begin
                want = expected_bars.pop_front();
                if (got.column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, got.column);
                    mismatches++;
                end
                if (got.bar_top !== want.bar_top) begin
                    $error("bar_top: expected %0d, got %0d", want.bar_top, got.bar_top);
                    mismatches++;
                end
                if (got.bar_bottom !== want.bar_bottom) begin
                    $error("bar_bottom: expected %0d, got %0d", want.bar_bottom,
                           got.bar_bottom);
                    mismatches++;
                end
                if (got.scaled_peak !== want.scaled_peak) begin
                    $error("scaled_peak: expected %0d, got %0d", want.scaled_peak,
                           got.scaled_peak);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [SAMPLE_W-1:0]  s_sample;
    logic                        s_last_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic [COLUMN_W-1:0]         m_column;
    logic [TOP_W-1:0]            m_bar_top;
    logic [BOTTOM_W-1:0]         m_bar_bottom;
    logic [SCALED_W-1:0]         m_scaled_peak;

    logic                        calm;
    int                          settings_used;
    bar_scoreboard               sb;

    waveform_column_peak_bars #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last_sample(s_last_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_column     (m_column),
        .m_bar_top    (m_bar_top),
        .m_bar_bottom (m_bar_bottom),
        .m_scaled_peak(m_scaled_peak)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_sample(s_sample, s_last_sample);
            end
            if (m_valid && m_ready) begin
                sb.check_result({m_column, m_bar_top, m_bar_bottom, m_scaled_peak});
            end
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 6) gap = $urandom_range(1, 3);
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_last_sample <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_bars.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, val);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd0;
            3:       return SAMPLE_W'($urandom_range(7) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic pick_settings();
        logic [CFG_DATA_W-1:0] val;
        if ($urandom_range(9) < 7) begin
            case ($urandom_range(9))
                0:       val = 0;
                1:       val = 1;
                2:       val = 40;
                default: val = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            write_reg(REG_SAMPLES_PER_COLUMN, val);
        end
        if ($urandom_range(9) < 7) begin
            case ($urandom_range(9))
                0:       val = 0;
                1:       val = MAX_COLUMNS;
                2:       val = 13'h1fff;
                3:       val = CFG_DATA_W'($urandom_range(4097, 8191));
                4:       val = CFG_DATA_W'($urandom_range(11, 4096));
                default: val = CFG_DATA_W'($urandom_range(1, 10));
            endcase
            write_reg(REG_COLUMN_COUNT, val);
        end
        if ($urandom_range(9) < 7) begin
            case ($urandom_range(9))
                0:       val = 0;
                1:       val = 1;
                2:       val = MIN_HEIGHT;
                3:       val = MAX_HEIGHT;
                4:       val = 13'h1fff;
                default: val = CFG_DATA_W'($urandom_range(3, 4095));
            endcase
            write_reg(REG_IMAGE_HEIGHT, val);
        end
        settings_used++;
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SAMPLES_PER_COLUMN;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_sample      = '0;
        s_last_sample = 1'b0;
        calm          = 1'b0;
        settings_used = 1;
        sb            = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: one sample per column, so every item yields a bar.
        push_sample(16'sd0, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh8001, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sh4000, 1'b0);
        push_sample(-16'sh4000, 1'b1);
        push_sample(16'sd123, 1'b0);
        drain_results();

        write_reg(REG_SAMPLES_PER_COLUMN, 3);
        write_reg(REG_COLUMN_COUNT, 2);
        write_reg(REG_IMAGE_HEIGHT, MIN_HEIGHT);
        write_reg(REG_UNUSED, 24'hffffff);
        settings_used++;
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd9, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd7, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh2000, 1'b0);
        push_sample(16'sh3000, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        drain_results();

        write_reg(REG_SAMPLES_PER_COLUMN, 24'hffffff);
        settings_used++;
        for (int i = 0; i < 12; i++) push_sample(pick_sample(), i % 6 == 5);
        drain_results();

        for (int phase = 0; phase < 12; phase++) begin
            pick_settings();
            calm = (phase == 5);
            for (int i = 0; i < 100; i++) begin
                push_sample(pick_sample(), $urandom_range(29) == 0);
            end
            drain_results();
            calm = 1'b0;
        end

        $display("Ran %0d samples under %0d register settings and compared %0d bars.",
                 sb.samples_taken, settings_used, sb.bars_checked);
        $display("Settings included clamped heights, column counts and group sizes.");
        if (sb.mismatches == 0 && sb.expected_bars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/wcpb_pkg.sv
design/wcpb_accum.sv
design/wcpb_scale.sv
design/waveform_column_peak_bars.sv
design/wcpb_checker.sv
verif/tb_top.sv
